[design/hsv_to_rgb_converter_defines.svh]
// assertion macros for the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// condition now implies condition in the next cycle
`define H2R_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

// condition implies another in the same cycle
`define H2R_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

[design/h2r_pkg.sv]
package h2r_pkg;

  // field widths
  localparam int HueW  = 15;
  localparam int PctW  = 7;
  localparam int ChanW = 8;

  // hue format and sector geometry
  localparam int HueFracBits = 6;
  localparam int SectorW     = 60 << HueFracBits;
  localparam int DW          = $clog2(SectorW + 1);

  // intermediate widths
  localparam int TW = 19;
  localparam int PW = TW + PctW;
  localparam int YW = PW + 5;
  localparam int ZW = 18;
  localparam int QW = ChanW + 1;
  localparam int MW = 2 * ZW;

  localparam logic [HueW-1:0] HueWrap = HueW'(6 * SectorW);
  localparam logic [TW-1:0]   FullT   = TW'(100 * SectorW);

  // channel = floor(17*v*t / 2560000) = floor(floor(17*v*t / 4096) / 625)
  localparam int             ScaleShift = 12;
  localparam logic [ZW-1:0]  ZCap       = ZW'(256 * 625);
  localparam int             RecipShift = 27;
  localparam logic [ZW-1:0]  RecipMul   = ZW'(214749);

  // 60 degree sectors, named by the color pair they span
  typedef enum logic [2:0] {
    SectRedYel = 3'd0,
    SectYelGrn = 3'd1,
    SectGrnCyn = 3'd2,
    SectCynBlu = 3'd3,
    SectBluMag = 3'd4,
    SectMagRed = 3'd5
  } sector_e;

  typedef logic [TW-1:0] tval_t;
  typedef logic [ZW-1:0] zval_t;

  // clipped weight v*t*17, scaled down by 4096 and capped at the saturation point
  function automatic zval_t scale_z(logic [PctW-1:0] v, tval_t t);
    logic [PW-1:0]   prod;
    logic [YW-1:0]   y;
    logic [YW-ScaleShift-1:0] z;
    prod = PW'(v) * PW'(t);
    y    = YW'({prod, 4'b0000}) + YW'(prod);
    z    = y[YW-1:ScaleShift];
    if (z >= (YW-ScaleShift)'(ZCap)) begin
      return ZCap;
    end
    return z[ZW-1:0];
  endfunction

  // divide by 625 through the reciprocal, saturate to 8 bits
  function automatic logic [ChanW-1:0] div_chan(zval_t z);
    logic [MW-1:0] qp;
    logic [QW-1:0] q;
    qp = MW'(z) * MW'(RecipMul);
    q  = qp[RecipShift +: QW];
    if (q[QW-1]) begin
      return '1;
    end
    return q[ChanW-1:0];
  endfunction

endpackage

[design/hsv_to_rgb_converter.sv]
// throughput: one beat per cycle; the five register stages advance together
// and hold when the output beat is not taken
// reset: asynchronous, active low, clears the stage valid bits only
module hsv_to_rgb_converter
  import h2r_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [HueW-1:0]   hue_i,
  input  logic [PctW-1:0]   saturation_i,
  input  logic [PctW-1:0]   brightness_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ChanW-1:0]  red_o,
  output logic [ChanW-1:0]  green_o,
  output logic [ChanW-1:0]  blue_o
);

`include "hsv_to_rgb_converter_defines.svh"

  logic adv;

  logic              s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic [HueW-1:0]   s1_hw_q, s1_hw_d;
  sector_e           s1_sec_q, s1_sec_d, s2_sec_q, s3_sec_q, s4_sec_q;
  logic [PctW-1:0]   s1_s_q, s2_s_q, s1_v_q, s2_v_q, s3_v_q;
  logic [DW-1:0]     s2_d_q, s2_d_d;
  tval_t             s3_tx_q, s3_tx_d, s3_tz_q, s3_tz_d;
  zval_t             s4_zc_q, s4_zx_q, s4_zz_q;
  logic [ChanW-1:0]  red_q, green_q, blue_q, red_d, green_d, blue_d;

  // whole pipe moves unless a finished beat is waiting
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = out_vld_q;
  assign red_o      = red_q;
  assign green_o    = green_q;
  assign blue_o     = blue_q;

  // stage 1: wrap hue into one turn and find its sector
  always_comb begin
    s1_hw_d = (hue_i >= HueWrap) ? hue_i - HueWrap : hue_i;
    priority if (s1_hw_d >= HueW'(5 * SectorW)) begin
      s1_sec_d = SectMagRed;
    end else if (s1_hw_d >= HueW'(4 * SectorW)) begin
      s1_sec_d = SectBluMag;
    end else if (s1_hw_d >= HueW'(3 * SectorW)) begin
      s1_sec_d = SectCynBlu;
    end else if (s1_hw_d >= HueW'(2 * SectorW)) begin
      s1_sec_d = SectGrnCyn;
    end else if (s1_hw_d >= HueW'(SectorW)) begin
      s1_sec_d = SectYelGrn;
    end else begin
      s1_sec_d = SectRedYel;
    end
  end

  // stage 2: distance of the hue from the middle of its sector pair
  always_comb begin
    logic [HueW-1:0] base;
    logic [DW-1:0]   off;
    unique case (s1_sec_q)
      SectRedYel: base = '0;
      SectYelGrn: base = HueW'(SectorW);
      SectGrnCyn: base = HueW'(2 * SectorW);
      SectCynBlu: base = HueW'(3 * SectorW);
      SectBluMag: base = HueW'(4 * SectorW);
      SectMagRed: base = HueW'(5 * SectorW);
      default:    base = '0;
    endcase
    off = DW'(s1_hw_q - base);
    // rising edge of the sector pair counts down, falling edge counts up
    s2_d_d = s1_sec_q[0] ? off : DW'(SectorW) - off;
  end

  // stage 3: weight 100*W - s*d for the intermediate and zero components
  always_comb begin
    tval_t sdx, sdz;
    sdx = TW'(s2_s_q) * TW'(s2_d_q);
    sdz = TW'(s2_s_q) * TW'(SectorW);
    s3_tx_d = (sdx >= FullT) ? '0 : FullT - sdx;
    s3_tz_d = (sdz >= FullT) ? '0 : FullT - sdz;
  end

  // stage 5: channel values, placed by sector
  always_comb begin
    logic [ChanW-1:0] cc, xx, zz;
    cc = div_chan(s4_zc_q);
    xx = div_chan(s4_zx_q);
    zz = div_chan(s4_zz_q);
    unique case (s4_sec_q)
      SectRedYel: begin red_d = cc; green_d = xx; blue_d = zz; end
      SectYelGrn: begin red_d = xx; green_d = cc; blue_d = zz; end
      SectGrnCyn: begin red_d = zz; green_d = cc; blue_d = xx; end
      SectCynBlu: begin red_d = zz; green_d = xx; blue_d = cc; end
      SectBluMag: begin red_d = xx; green_d = zz; blue_d = cc; end
      default:    begin red_d = cc; green_d = zz; blue_d = xx; end
    endcase
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_hw_q  <= s1_hw_d;
      s1_sec_q <= s1_sec_d;
      s1_s_q   <= saturation_i;
      s1_v_q   <= brightness_i;

      s2_d_q   <= s2_d_d;
      s2_sec_q <= s1_sec_q;
      s2_s_q   <= s1_s_q;
      s2_v_q   <= s1_v_q;

      s3_tx_q  <= s3_tx_d;
      s3_tz_q  <= s3_tz_d;
      s3_sec_q <= s2_sec_q;
      s3_v_q   <= s2_v_q;

      s4_zc_q  <= scale_z(s3_v_q, FullT);
      s4_zx_q  <= scale_z(s3_v_q, s3_tx_q);
      s4_zz_q  <= scale_z(s3_v_q, s3_tz_q);
      s4_sec_q <= s3_sec_q;

      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
    end
  end

  // checks
  `H2R_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, s1_vld_q, "accepted beat lost")
  `H2R_ASSERT_NOW(a_dist_in_range, s2_vld_q, s2_d_q <= DW'(SectorW), "hue distance out of range")
  `H2R_ASSERT_NOW(a_weight_order, s3_vld_q, s3_tx_q >= s3_tz_q, "component weights out of order")

endmodule
